### hdl/tld_pkg.sv
// Shared types and constants for the terminal line discipline.
package tld_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int BYTE_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 1;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_TX_SLOT = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO_ENABLE    = 2'd0,
        CFG_CANONICAL_MODE = 2'd1
    } cfg_idx_t;

    // Request into one ring.
    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] push_data;
        logic              pop;
    } ring_ctrl_t;

    // Status out of one ring.
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BYTE_W-1:0] count;
    } ring_stat_t;

endpackage

### hdl/tld_item_if.sv
// Input item channel: operation and byte.
interface tld_item_if
    import tld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output operation, output byte_in, input ready);
    modport sink   (input valid, input operation, input byte_in, output ready);
endinterface

### hdl/tld_result_if.sv
// Result item channel: one result per input transaction.
interface tld_result_if
    import tld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              uart_send_valid;
    logic              read_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              line_end;
    logic              write_accepted;
    logic              wake_reader;
    logic              wake_writer;
    logic              tx_irq_enable;
    logic              rx_ready;
    logic [BYTE_W-1:0] rx_count;
    logic [BYTE_W-1:0] tx_count;

    modport source (
        output valid, input ready,
        output uart_send_valid, output read_valid, output data_byte, output line_end,
        output write_accepted, output wake_reader, output wake_writer,
        output tx_irq_enable, output rx_ready, output rx_count, output tx_count
    );
    modport sink (
        input valid, output ready,
        input uart_send_valid, input read_valid, input data_byte, input line_end,
        input write_accepted, input wake_reader, input wake_writer,
        input tx_irq_enable, input rx_ready, input rx_count, input tx_count
    );
endinterface

### hdl/tld_cfg_if.sv
// Configuration write channel: register index and data.
interface tld_cfg_if
    import tld_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/terminal_line_discipline.sv
// Top level of the terminal line discipline: sequencer, newline counter, two rings.
// The block keeps a receive ring and a transmit ring, each RING_DEPTH slots of
// synchronous memory with one slot always left empty, so each holds at most
// RING_DEPTH-1 bytes. Each input transaction carries one of four operations
// (received byte, software write, read, transmit slot free) and yields exactly
// one result transaction with the status after the step. Items are handled one
// at a time: after acceptance the sequencer goes to its final state, where the
// result register is loaded, passing first through an extra push state when an
// LF is expanded to CR LF in the transmit ring, because the transmit memory has
// one write port and takes one byte per cycle. The ring memories' registered
// read ports make a popped byte available by the final state. A finished result
// waits in the output register, and the next item can be accepted meanwhile;
// while that register is still occupied, the item after it holds the sequencer
// in its final state and the input stalls until the register frees.
// rx_count and tx_count are the low 8 bits of each ring's fill. Memory contents
// are not cleared after reset; only written slots are ever read. Configuration
// writes are always taken and must only be issued while the block is idle.
module terminal_line_discipline
    import tld_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    tld_item_if.sink           item,
    tld_result_if.source       result,
    tld_cfg_if.sink            cfg
);
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PUSH2 = 3'b010,
        ST_FIN   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic echo_reg, echo_next;
    logic canon_reg, canon_next;

    // Newline counter, saturating
    logic [BYTE_W-1:0] nl_reg, nl_next;

    // Per-item flags captured at acceptance
    logic send_v_reg, read_v_reg, wacc_reg, wrd_reg, wwr_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              o_send_reg, o_read_reg, o_lend_reg, o_wacc_reg;
    logic              o_wrd_reg, o_wwr_reg, o_txirq_reg, o_rxrdy_reg;
    logic [BYTE_W-1:0] o_data_reg, o_rxcnt_reg, o_txcnt_reg;

    ring_ctrl_t        rx_ctrl, tx_ctrl;
    ring_stat_t        rx_stat, tx_stat;
    logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;

    logic              accept, load;
    op_t               op;
    logic [BYTE_W-1:0] b_rx, b_tx;
    logic              rx_ready_now, rx_ready_fin, read_lf;
    logic              tx_push1, need_push2;

    tld_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rx_ctrl),
        .stat    (rx_stat),
        .rd_data (rx_rd_data)
    );

    tld_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tx_ctrl),
        .stat    (tx_stat),
        .rd_data (tx_rd_data)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign op         = op_t'(item.operation);
    assign cfg.ready  = 1'b1;

    // CR is folded into LF on receive; the transmit side expands LF to CR LF.
    assign b_rx = (item.byte_in == CH_CR) ? CH_LF : item.byte_in;
    assign b_tx = (op == OP_RX_BYTE) ? b_rx : item.byte_in;

    assign rx_ready_now = !rx_stat.empty && !(canon_reg && nl_reg == '0);

    // First transmit byte: a CR ahead of an LF, else the byte itself.
    // A write needs a free slot; an echo simply drops what finds none.
    assign tx_push1   = accept && !tx_stat.full
                     && ((op == OP_RX_BYTE && echo_reg) || op == OP_WRITE);
    assign need_push2 = tx_push1 && (b_tx == CH_LF);

    always_comb
    begin
        rx_ctrl.push      = accept && (op == OP_RX_BYTE) && !rx_stat.full;
        rx_ctrl.push_data = b_rx;
        rx_ctrl.pop       = accept && (op == OP_READ) && rx_ready_now;

        tx_ctrl.pop       = accept && (op == OP_TX_SLOT) && !tx_stat.empty;
        if (state_reg == ST_PUSH2)
        begin
            tx_ctrl.push      = !tx_stat.full;
            tx_ctrl.push_data = CH_LF;
        end
        else
        begin
            tx_ctrl.push      = tx_push1;
            tx_ctrl.push_data = (b_tx == CH_LF) ? CH_CR : b_tx;
        end
    end

    // Popped byte comes from the ring's read register, so an LF read is counted down
    // once, at the edge that loads the result.
    assign read_lf = load && read_v_reg && (rx_rd_data == CH_LF);

    always_comb
    begin
        nl_next = nl_reg;
        if (rx_ctrl.push && b_rx == CH_LF && nl_reg != BYTE_MAX)
            nl_next = nl_reg + 1'b1;
        else if (read_lf && nl_reg != '0)
            nl_next = nl_reg - 1'b1;
    end

    assign rx_ready_fin = !rx_stat.empty && !(canon_reg && nl_next == '0);

    assign load = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = need_push2 ? ST_PUSH2 : ST_FIN;
            ST_PUSH2:
                state_next = ST_FIN;
            ST_FIN:
                if (load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        echo_next  = echo_reg;
        canon_next = canon_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ECHO_ENABLE:    echo_next  = cfg.data[0];
                CFG_CANONICAL_MODE: canon_next = cfg.data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            echo_reg      <= 1'b1;
            canon_reg     <= 1'b1;
            nl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            echo_reg      <= echo_next;
            canon_reg     <= canon_next;
            nl_reg        <= nl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_v_reg <= tx_ctrl.pop;
            wwr_reg    <= tx_ctrl.pop;
            read_v_reg <= rx_ctrl.pop;
            wacc_reg   <= (op == OP_WRITE) && !tx_stat.full;
            wrd_reg    <= (op == OP_RX_BYTE) && (!canon_reg || b_rx == CH_LF);
        end
    end

    // Result register: status is sampled after all ring updates of the item.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_send_reg  <= send_v_reg;
            o_read_reg  <= read_v_reg;
            o_data_reg  <= read_v_reg ? rx_rd_data : (send_v_reg ? tx_rd_data : '0);
            o_lend_reg  <= read_v_reg && canon_reg && (rx_rd_data == CH_LF);
            o_wacc_reg  <= wacc_reg;
            o_wrd_reg   <= wrd_reg;
            o_wwr_reg   <= wwr_reg;
            o_txirq_reg <= !tx_stat.empty;
            o_rxrdy_reg <= rx_ready_fin;
            o_rxcnt_reg <= rx_stat.count;
            o_txcnt_reg <= tx_stat.count;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.uart_send_valid = o_send_reg;
    assign result.read_valid      = o_read_reg;
    assign result.data_byte       = o_data_reg;
    assign result.line_end        = o_lend_reg;
    assign result.write_accepted  = o_wacc_reg;
    assign result.wake_reader     = o_wrd_reg;
    assign result.wake_writer     = o_wwr_reg;
    assign result.tx_irq_enable   = o_txirq_reg;
    assign result.rx_ready        = o_rxrdy_reg;
    assign result.rx_count        = o_rxcnt_reg;
    assign result.tx_count        = o_txcnt_reg;
endmodule

### hdl/tld_ring.sv
// Byte ring: synchronous memory with write/read pointers and fill status.
module tld_ring
    import tld_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ring_ctrl_t        ctrl,
    output ring_stat_t        stat,
    output logic [BYTE_W-1:0] rd_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int FW = (AW + 1 > BYTE_W) ? AW + 1 : BYTE_W;
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_inc, rd_ptr_inc;
    logic [AW:0]   fill_w;
    logic [FW-1:0] fill_x;

    // Wrap explicitly so depths that are not a power of two work.
    assign wr_ptr_inc = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;

    assign wr_ptr_next = ctrl.push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = ctrl.pop  ? rd_ptr_inc : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[wr_ptr_reg] <= ctrl.push_data;
        if (ctrl.pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    assign fill_w = (wr_ptr_reg >= rd_ptr_reg)
                  ? {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg}
                  : {1'b0, wr_ptr_reg} + DEPTH_W - {1'b0, rd_ptr_reg};
    assign fill_x = FW'(fill_w);

    // One slot stays empty: full when the next write slot is the read slot.
    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full  = (wr_ptr_inc == rd_ptr_reg);
    assign stat.count = fill_x[BYTE_W-1:0];
    assign rd_data    = rd_data_reg;
endmodule
